>>> rtl/lprp_pkg.sv
// Types and constants shared by the length-prefixed request parser.
package lprp_pkg;

    localparam logic [7:0] CMD_MAX  = 8'h09;
    localparam logic [7:0] CMD_HOLE = 8'h08;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_req;

    typedef struct packed {
        logic [2:0] parse_status;
        logic [3:0] command_code;
        logic [7:0] arg_data;
        logic       arg_data_valid;
        logic       arg_number;
        logic       arg_end;
        logic [7:0] arg_length;
    } t_rsp;

endpackage

>>> rtl/length_prefixed_request_parser.sv
// Length-prefixed request parser: byte-wise request decoder with registered result.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the output is not stalled; the
// parse state update and the result are computed together combinationally, and
// the one-entry output register is refilled in the cycle its beat is taken.
// Reset: synchronous, active low; clears parse state and the output valid.
module length_prefixed_request_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lprp_pkg::t_req       i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lprp_pkg::t_rsp       o_out_data
);
    import lprp_pkg::*;

    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_COUNT = 3'd1,
        PH_LEN   = 3'd2,
        PH_ARG   = 3'd3,
        PH_DONE  = 3'd4,
        PH_BAD   = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase, c_phase;
    logic [3:0] r_cmd, n_cmd, c_cmd;
    logic [7:0] r_args_total, n_args_total, c_args_total;
    logic [7:0] r_args_seen, n_args_seen, c_args_seen;
    logic [7:0] r_bytes_total, n_bytes_total, c_bytes_total;
    logic [7:0] r_bytes_seen, n_bytes_seen, c_bytes_seen;
    logic       r_out_valid;
    t_rsp       r_out_data, n_out_data;
    logic       accept;
    logic       low_arg;
    logic [7:0] args_inc;
    logic [7:0] bytes_inc;
    logic [7:0] c;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign c           = i_in_data.data_byte;

    always_comb begin
        // restart returns to reset values before the byte is handled
        if (i_in_data.restart) begin
            c_phase       = PH_CMD;
            c_cmd         = '0;
            c_args_total  = '0;
            c_args_seen   = '0;
            c_bytes_total = '0;
            c_bytes_seen  = '0;
        end else begin
            c_phase       = r_phase;
            c_cmd         = r_cmd;
            c_args_total  = r_args_total;
            c_args_seen   = r_args_seen;
            c_bytes_total = r_bytes_total;
            c_bytes_seen  = r_bytes_seen;
        end

        low_arg   = (c_args_seen < 8'd2);
        args_inc  = c_args_seen + 8'd1;
        bytes_inc = c_bytes_seen + 8'd1;

        n_phase       = c_phase;
        n_cmd         = c_cmd;
        n_args_total  = c_args_total;
        n_args_seen   = c_args_seen;
        n_bytes_total = c_bytes_total;
        n_bytes_seen  = c_bytes_seen;

        n_out_data                = '0;

        case (c_phase)
            PH_CMD: begin
                if (c <= CMD_MAX && c != CMD_HOLE) begin
                    n_cmd   = c[3:0];
                    n_phase = PH_COUNT;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_COUNT: begin
                n_args_total = c;
                n_args_seen  = '0;
                n_phase      = (c == 8'd0) ? PH_DONE : PH_LEN;
            end
            PH_LEN: begin
                n_bytes_total = c;
                n_bytes_seen  = '0;
                if (c == 8'd0) begin
                    if (low_arg) begin
                        n_out_data.arg_end    = 1'b1;
                        n_out_data.arg_number = c_args_seen[0];
                    end
                    n_args_seen = args_inc;
                    n_phase     = (args_inc >= c_args_total) ? PH_DONE : PH_LEN;
                end else begin
                    n_phase = PH_ARG;
                end
            end
            PH_ARG: begin
                if (low_arg) begin
                    n_out_data.arg_data_valid = 1'b1;
                    n_out_data.arg_data       = c;
                    n_out_data.arg_number     = c_args_seen[0];
                end
                n_bytes_seen = bytes_inc;
                if (bytes_inc >= c_bytes_total) begin
                    if (low_arg) begin
                        n_out_data.arg_end = 1'b1;
                    end
                    n_args_seen = args_inc;
                    n_phase     = (args_inc >= c_args_total) ? PH_DONE : PH_LEN;
                end
            end
            PH_DONE, PH_BAD: begin
                n_phase = c_phase;
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        n_out_data.parse_status = n_phase;
        n_out_data.command_code = n_cmd;
        n_out_data.arg_length   = n_bytes_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CMD;
            r_cmd         <= '0;
            r_args_total  <= '0;
            r_args_seen   <= '0;
            r_bytes_total <= '0;
            r_bytes_seen  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_cmd         <= n_cmd;
                r_args_total  <= n_args_total;
                r_args_seen   <= n_args_seen;
                r_bytes_total <= n_bytes_total;
                r_bytes_seen  <= n_bytes_seen;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // restart with the hole command always lands in the invalid status
    a_restart_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.restart && i_in_data.data_byte == CMD_HOLE
        |=> o_out_valid && o_out_data.parse_status == PH_BAD)
        else $error("restart with invalid command did not give invalid status");

    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.arg_data_valid
        |-> o_out_data.parse_status == PH_LEN || o_out_data.parse_status == PH_ARG
            || o_out_data.parse_status == PH_DONE)
        else $error("argument data beat with wrong status");

    a_empty_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.arg_end && !o_out_data.arg_data_valid
        |-> o_out_data.arg_length == 8'd0 && o_out_data.arg_data == 8'd0)
        else $error("argument end without data on nonzero length");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule
